// ===== src/mma_pkg.sv =====
// ----------------------------------------------------------------------------
// mma_pkg: shared types and constants of the moving average block
// field widths, default sizes, controller states and the control structs
// exchanged between controller and datapath
// ----------------------------------------------------------------------------
package mma_pkg;

  localparam int CH_W          = 3;   // channel field
  localparam int SAMPLE_W      = 16;  // sample field
  localparam int AVG_W         = 16;  // average field
  localparam int WIN_CFG_W     = 6;   // window register width
  localparam int CFG_IDX_W     = 3;   // register index width
  localparam int MAX_WINDOW_DEF = 32;
  localparam int CHANNELS_DEF   = 6;

  localparam logic [WIN_CFG_W-1:0] WIN_RESET = WIN_CFG_W'(8);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_UPDATE,
    ST_DIV,
    ST_DONE
  } mma_state_t;

  // controller to datapath
  typedef struct packed {
    logic clr;        // write zero at the clearing address and advance
    logic capture;    // latch the accepted beat
    logic rd;         // read the oldest sample of the channel
    logic upd;        // update store, total and ring position
    logic div_start;  // launch the divider on the new total
    logic out_load;   // load the result register
  } mma_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clr_last;   // clearing address at its last entry
    logic ch_ok;      // captured channel is in range
    logic div_busy;   // divider still iterating
    logic out_free;   // result register may be loaded
  } mma_sts_t;

endpackage

// ===== src/mma_in_if.sv =====
// ----------------------------------------------------------------------------
// mma_in_if: input beat channel
// valid/ready handshake carrying channel and sample
// ----------------------------------------------------------------------------
interface mma_in_if
  import mma_pkg::*;
  ;
  logic                valid;
  logic                ready;
  logic [CH_W-1:0]     channel;
  logic [SAMPLE_W-1:0] sample;

  modport source (output valid, output channel, output sample, input ready);
  modport sink   (input valid, input channel, input sample, output ready);
endinterface

// ===== src/mma_out_if.sv =====
// ----------------------------------------------------------------------------
// mma_out_if: result beat channel
// valid/ready handshake carrying the average
// ----------------------------------------------------------------------------
interface mma_out_if
  import mma_pkg::*;
  ;
  logic             valid;
  logic             ready;
  logic [AVG_W-1:0] average;

  modport source (output valid, output average, input ready);
  modport sink   (input valid, input average, output ready);
endinterface

// ===== src/mma_ram.sv =====
// ----------------------------------------------------------------------------
// mma_ram: generic single-clock ram
// one write port, one read port with registered read data
// ----------------------------------------------------------------------------
module mma_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 192
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== src/mma_div.sv =====
// ----------------------------------------------------------------------------
// mma_div: serial restoring divider
// one quotient bit per cycle, every dividend bit shifted through per division
// ----------------------------------------------------------------------------
module mma_div #(
  parameter int NUM_W = 21,
  parameter int DEN_W = 6
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] dividend,
  input  logic [DEN_W-1:0] divisor,
  output logic             busy,
  output logic [NUM_W-1:0] quotient
);

  localparam int CNT_W = $clog2(NUM_W);

  logic             busy_r, busy_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [NUM_W-1:0] quo_r, quo_nxt;
  logic [DEN_W-1:0] rem_r, rem_nxt;
  logic [DEN_W-1:0] den_r, den_nxt;
  logic [DEN_W:0]   shifted;
  logic             ge;

  always_comb begin
    shifted  = {rem_r, quo_r[NUM_W-1]};
    ge       = (shifted >= {1'b0, den_r});
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(NUM_W - 1);
      quo_nxt  = dividend;
      rem_nxt  = '0;
      den_nxt  = divisor;
    end else if (busy_r) begin
      quo_nxt = {quo_r[NUM_W-2:0], ge};
      rem_nxt = ge ? DEN_W'(shifted - {1'b0, den_r}) : DEN_W'(shifted);
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
      end else begin
        cnt_nxt = cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign busy     = busy_r;
  assign quotient = quo_r;

endmodule

// ===== src/mma_ctrl.sv =====
// ----------------------------------------------------------------------------
// mma_ctrl: sequencing state machine
// clearing pass, then capture, read, update and divide if the channel is in range, and hand over per beat
// ----------------------------------------------------------------------------
module mma_ctrl
  import mma_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_accept,
  output logic     in_ready,
  output mma_cmd_t cmd,
  input  mma_sts_t sts
);

  mma_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.clr = 1'b1;
        if (sts.clr_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_accept) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_READ;
        end
      end
      ST_READ: begin
        if (sts.ch_ok) begin
          cmd.rd    = 1'b1;
          state_nxt = ST_UPDATE;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_UPDATE: begin
        cmd.upd       = 1'b1;
        cmd.div_start = 1'b1;
        state_nxt     = ST_DIV;
      end
      ST_DIV: begin
        if (!sts.div_busy) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  // a capture always leads into the read step
  a_capture_then_read: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.capture |=> (state_r == ST_READ))
    else $error("capture not followed by read");

  // no beat is taken while the store is being cleared
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLEAR) |-> !cmd.capture && !cmd.upd)
    else $error("activity during clearing pass");

endmodule

// ===== src/mma_dpath.sv =====
// ----------------------------------------------------------------------------
// mma_dpath: datapath of the moving average
// window registers, totals, ring positions, sample ram, divider, result reg
// ----------------------------------------------------------------------------
module mma_dpath
  import mma_pkg::*;
#(
  parameter int MAX_WINDOW = MAX_WINDOW_DEF,
  parameter int CHANNELS   = CHANNELS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  mma_cmd_t             cmd,
  output mma_sts_t             sts,
  input  logic [CH_W-1:0]      in_channel,
  input  logic [SAMPLE_W-1:0]  in_sample,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [WIN_CFG_W-1:0] cfg_wdata,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [AVG_W-1:0]     out_average
);

  localparam int PW    = $clog2(MAX_WINDOW);
  localparam int WW    = $clog2(MAX_WINDOW + 1);
  localparam int TW    = SAMPLE_W + $clog2(MAX_WINDOW);
  localparam int CAW   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int DEPTH = CHANNELS * (2 ** PW);
  localparam int AW    = $clog2(DEPTH);

  logic [WIN_CFG_W-1:0] win_r [CHANNELS];
  logic [TW-1:0]        tot_r [CHANNELS];
  logic [PW-1:0]        pos_r [CHANNELS];
  logic [AW-1:0]        clr_addr_r;
  logic [CH_W-1:0]      ch_r;
  logic [SAMPLE_W-1:0]  sample_r;
  logic                 out_valid_r;
  logic [AVG_W-1:0]     avg_r;

  logic [CAW-1:0]       ch_idx;
  logic [CAW-1:0]       cfg_idx;
  logic                 ch_ok;
  logic [WIN_CFG_W-1:0] win_raw;
  logic [WW-1:0]        win_eff;
  logic [AW-1:0]        addr;
  logic [SAMPLE_W-1:0]  old_sample;
  logic [TW-1:0]        tot_new;
  logic [PW:0]          pos_inc;
  logic [PW-1:0]        pos_next;
  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  logic [SAMPLE_W-1:0]  ram_wdata;
  logic                 div_busy;
  logic [TW-1:0]        quotient;
  logic [AVG_W-1:0]     avg_sat;

  assign ch_idx  = CAW'(ch_r);
  assign cfg_idx = CAW'(cfg_index);
  assign ch_ok   = (32'(ch_r) < CHANNELS);

  // effective window: zero acts as one, oversize saturates
  always_comb begin
    win_raw = win_r[ch_idx];
    if (win_raw == '0) begin
      win_eff = WW'(1);
    end else if (32'(win_raw) > MAX_WINDOW) begin
      win_eff = WW'(MAX_WINDOW);
    end else begin
      win_eff = WW'(win_raw);
    end
  end

  assign addr     = AW'({ch_idx, pos_r[ch_idx]});
  assign tot_new  = tot_r[ch_idx] - TW'(old_sample) + TW'(sample_r);
  assign pos_inc  = (PW+1)'(pos_r[ch_idx]) + 1'b1;
  assign pos_next = (pos_inc >= (PW+1)'(win_eff)) ? '0 : PW'(pos_inc);

  assign ram_we    = cmd.clr || cmd.upd;
  assign ram_waddr = cmd.clr ? clr_addr_r : addr;
  assign ram_wdata = cmd.clr ? '0 : sample_r;

  mma_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (cmd.rd),
    .raddr (addr),
    .rdata (old_sample)
  );

  mma_div #(
    .NUM_W (TW),
    .DEN_W (WW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (tot_new),
    .divisor  (win_eff),
    .busy     (div_busy),
    .quotient (quotient)
  );

  assign avg_sat = (|quotient[TW-1:AVG_W]) ? '1 : quotient[AVG_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CHANNELS; i++) begin
        win_r[i] <= WIN_RESET;
        tot_r[i] <= '0;
        pos_r[i] <= '0;
      end
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we && (32'(cfg_index) < CHANNELS)) begin
        win_r[cfg_idx] <= cfg_wdata;
      end
      if (cmd.clr) begin
        clr_addr_r <= clr_addr_r + 1'b1;
      end
      if (cmd.upd) begin
        tot_r[ch_idx] <= tot_new;
        pos_r[ch_idx] <= pos_next;
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      ch_r     <= in_channel;
      sample_r <= in_sample;
    end
    if (cmd.out_load) begin
      avg_r <= ch_ok ? avg_sat : '0;
    end
  end

  assign sts.clr_last = (clr_addr_r == AW'(DEPTH - 1));
  assign sts.ch_ok    = ch_ok;
  assign sts.div_busy = div_busy;
  assign sts.out_free = !out_valid_r || out_ready;

  assign out_valid   = out_valid_r;
  assign out_average = avg_r;

  // a waiting result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || out_ready))
    else $error("result register overwritten");

  // the divider is never restarted mid division
  a_div_idle_at_start: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |-> !div_busy)
    else $error("divider restarted while busy");

  // state changes only for channels in range
  a_update_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.upd || cmd.rd) |-> ch_ok)
    else $error("update for out of range channel");

endmodule

// ===== src/multichannel_moving_average.sv =====
// ----------------------------------------------------------------------------
// multichannel_moving_average: per-channel running moving average
// per beat: capture, then for a channel in range read of the oldest sample, update
//   of the TW-bit total (TW = 16+log2 MAX_WINDOW) and division by the serial divider
//   at one bit per cycle; then load of the result register, one beat at a time
// reset: windows to 8, totals and ring positions to zero, then a clearing pass
//   zeroes all CHANNELS*2^log2(MAX_WINDOW) entries (192 at defaults) of the sample
//   ram; no input beat is taken during it, configuration writes still are
// ----------------------------------------------------------------------------
module multichannel_moving_average
  import mma_pkg::*;
#(
  parameter int MAX_WINDOW = MAX_WINDOW_DEF,
  parameter int CHANNELS   = CHANNELS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  mma_in_if.sink               in_bus,
  mma_out_if.source            out_bus,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [WIN_CFG_W-1:0] cfg_wdata
);

  // command and status between the sequencer and the datapath
  mma_cmd_t cmd;
  mma_sts_t sts;
  logic     in_ready;
  logic     in_accept;

  // an input beat moves when both sides agree
  assign in_accept    = in_bus.valid && in_ready;
  assign in_bus.ready = in_ready;

  // sequencer: clearing pass after reset, then per beat capture and, for a channel
  // in range, read oldest sample, update, divide; then hand over
  mma_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_accept (in_accept),
    .in_ready  (in_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  // datapath: per-channel window, total and ring index registers,
  // the sample ram, the serial divider and the result register,
  // which lets the next beat in while a result still waits
  mma_dpath #(
    .MAX_WINDOW (MAX_WINDOW),
    .CHANNELS   (CHANNELS)
  ) u_dpath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sts         (sts),
    .in_channel  (in_bus.channel),
    .in_sample   (in_bus.sample),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .out_valid   (out_bus.valid),
    .out_ready   (out_bus.ready),
    .out_average (out_bus.average)
  );

endmodule

// ===== dv/multichannel_moving_average_tb.sv =====
// ----------------------------------------------------------------------------
// multichannel_moving_average_tb: self-checking bench of the moving average
// drives sample beats on all channels, in range and beyond, across many window
// settings, predicts every average in a scoreboard and compares each result
// beat in order; random idling on both sides, a long receiver hold-off and
// pauses until the block has drained
// ----------------------------------------------------------------------------
module multichannel_moving_average_tb
  import mma_pkg::*;
  ;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_CH      = CHANNELS_DEF;
  localparam int WIN_MAX     = MAX_WINDOW_DEF;
  localparam int REG_SLOTS   = 1 << CFG_IDX_W;
  localparam int PHASES      = 16;
  localparam int PHASE_BEATS = 100;
  localparam int HOLD_CYCLES = 400;
  localparam int TAIL_CYCLES = 40;
  localparam int IDLE_PCT    = 27;
  localparam int MAX_REPORTS = 10;

  // register indexes: one window per channel, the top two address nothing
  localparam logic [CFG_IDX_W-1:0] WIN_IDX_CH0 = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] WIN_IDX_CH1 = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] WIN_IDX_CH2 = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] WIN_IDX_CH3 = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] WIN_IDX_CH4 = CFG_IDX_W'(4);
  localparam logic [CFG_IDX_W-1:0] WIN_IDX_CH5 = CFG_IDX_W'(5);
  localparam logic [CFG_IDX_W-1:0] SPARE_IDX_LO = CFG_IDX_W'(6);
  localparam logic [CFG_IDX_W-1:0] SPARE_IDX_HI = CFG_IDX_W'(7);

  // scoreboard: own copy of ring stores, totals and windows, plus the
  // averages still owed by the block, oldest first
  class avg_tracker;
    logic [SAMPLE_W-1:0]  slots [NUM_CH][WIN_MAX];
    logic [20:0]          totals [NUM_CH];
    int unsigned          ring_pos [NUM_CH];
    logic [WIN_CFG_W-1:0] windows [NUM_CH];
    logic [AVG_W-1:0]     owed_avgs [$];
    int                   mismatches;

    function new();
      for (int c = 0; c < NUM_CH; c++) begin
        for (int s = 0; s < WIN_MAX; s++) slots[c][s] = '0;
        totals[c]   = '0;
        ring_pos[c] = 0;
        windows[c]  = WIN_RESET;
      end
      mismatches = 0;
    endfunction

    function void set_window(logic [CFG_IDX_W-1:0] idx, logic [WIN_CFG_W-1:0] val);
      if (idx < NUM_CH) windows[idx] = val;
    endfunction

    function int outstanding();
      return owed_avgs.size();
    endfunction

    // accepted input beat: advance the channel and note the average it owes
    function void take_sample(logic [CH_W-1:0] ch, logic [SAMPLE_W-1:0] smp);
      int unsigned w;
      int unsigned pos;
      int unsigned quot;
      if (ch >= NUM_CH) begin
        owed_avgs.push_back('0);
        return;
      end
      w = windows[ch];
      if (w == 0) w = 1;
      else if (w > WIN_MAX) w = WIN_MAX;
      pos = ring_pos[ch];
      if (pos >= WIN_MAX) pos = 0;
      totals[ch] = totals[ch] - 21'(slots[ch][pos]) + 21'(smp);
      slots[ch][pos] = smp;
      pos = pos + 1;
      if (pos >= w) pos = 0;
      ring_pos[ch] = pos;
      quot = int'(totals[ch]) / w;
      if (quot > 32'hFFFF) quot = 32'hFFFF;
      owed_avgs.push_back(AVG_W'(quot));
    endfunction

    function void check_average(logic [AVG_W-1:0] got);
      logic [AVG_W-1:0] want;
      if (owed_avgs.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: result beat %0d with no average owed", $realtime, got);
        return;
      end
      want = owed_avgs.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: average mismatch: expected %0d, got %0d", $realtime, want, got);
      end
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [WIN_CFG_W-1:0] cfg_wdata;

  mma_in_if  in_bus ();
  mma_out_if out_bus ();

  multichannel_moving_average dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_bus    (in_bus),
    .out_bus   (out_bus),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  avg_tracker           tracker = new();
  logic [WIN_CFG_W-1:0] window_plan [REG_SLOTS];
  bit                   no_idle = 1'b0;       // quiet stretch: neither side idles
  bit                   hold_request = 1'b0;  // ask the receiver for a long hold-off

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // safety net against a hung handshake
  initial begin
    #1_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic bit idle_now();
    return !no_idle && ($urandom_range(99) < IDLE_PCT);
  endfunction

  // biased towards the extremes so that saturation and zero totals show up
  function automatic logic [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      2:       return SAMPLE_W'($urandom_range(15));
      3:       return SAMPLE_W'($urandom_range(65535, 65000));
      default: return SAMPLE_W'($urandom_range(65535));
    endcase
  endfunction

  // mostly real channels, a few beats on the two unused codes
  function automatic logic [CH_W-1:0] pick_channel();
    if ($urandom_range(99) < 5) return CH_W'($urandom_range(7, NUM_CH));
    return CH_W'($urandom_range(NUM_CH - 1));
  endfunction

  // window values beyond the legal range included: zero and above the maximum
  function automatic logic [WIN_CFG_W-1:0] pick_window();
    case ($urandom_range(11))
      0:       return '0;
      1:       return WIN_CFG_W'(1);
      2:       return WIN_CFG_W'(WIN_MAX);
      3:       return '1;
      4:       return WIN_CFG_W'($urandom_range(63, WIN_MAX + 1));
      default: return WIN_CFG_W'($urandom_range(WIN_MAX, 1));
    endcase
  endfunction

  // one input beat, with random idle cycles ahead of it; valid stays high on return
  task automatic send_beat(input logic [CH_W-1:0] ch, input logic [SAMPLE_W-1:0] smp);
    while (idle_now()) begin
      in_bus.valid <= 1'b0;
      @(posedge clk);
    end
    in_bus.valid   <= 1'b1;
    in_bus.channel <= ch;
    in_bus.sample  <= smp;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    tracker.take_sample(ch, smp);
  endtask

  // stop offering and wait for every owed average to come back
  task automatic drain_results();
    in_bus.valid <= 1'b0;
    do @(posedge clk); while (tracker.outstanding() != 0);
  endtask

  // write every register from window_plan, block idle
  task automatic program_windows();
    for (int i = 0; i < REG_SLOTS; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= CFG_IDX_W'(i);
      cfg_wdata <= window_plan[i];
      @(posedge clk);
      tracker.set_window(CFG_IDX_W'(i), window_plan[i]);
    end
    cfg_we <= 1'b0;
  endtask

  // result side: random back-pressure, or a long hold-off when asked
  initial begin
    out_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request  <= 1'b0;
        out_bus.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_bus.ready <= !idle_now();
      end
    end
  end

  // every accepted result beat goes to the scoreboard
  always @(posedge clk) begin
    if (rst_n && out_bus.valid && out_bus.ready) tracker.check_average(out_bus.average);
  end

  initial begin
    rst_n          <= 1'b0;
    in_bus.valid   <= 1'b0;
    in_bus.channel <= '0;
    in_bus.sample  <= '0;
    cfg_we         <= 1'b0;
    cfg_index      <= '0;
    cfg_wdata      <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // directed: reset windows, field extremes, unused channel codes
    // (input ready stays low through the clearing pass, the handshake waits)
    send_beat(CH_W'(0), '0);
    send_beat(CH_W'(0), '1);
    send_beat(CH_W'(0), '1);
    send_beat(CH_W'(5), '1);
    send_beat(CH_W'(5), '0);
    send_beat(CH_W'(6), SAMPLE_W'(16'h1234));
    send_beat(CH_W'(7), '1);
    send_beat(CH_W'(3), SAMPLE_W'(1));
    send_beat(CH_W'(2), SAMPLE_W'(16'h8000));
    drain_results();

    // window shrunk under the ring position, zero window, oversized window,
    // writes to the unused indexes
    window_plan[WIN_IDX_CH0]  = WIN_CFG_W'(1);
    window_plan[WIN_IDX_CH1]  = '0;
    window_plan[WIN_IDX_CH2]  = '1;
    window_plan[WIN_IDX_CH3]  = WIN_CFG_W'(WIN_MAX);
    window_plan[WIN_IDX_CH4]  = WIN_CFG_W'(1);
    window_plan[WIN_IDX_CH5]  = WIN_CFG_W'(2);
    window_plan[SPARE_IDX_LO] = WIN_CFG_W'(5);
    window_plan[SPARE_IDX_HI] = '1;
    program_windows();

    // stale samples on channel 0 push the quotient past the field: saturates
    send_beat(CH_W'(0), '1);
    send_beat(CH_W'(0), '0);
    send_beat(CH_W'(1), '1);
    send_beat(CH_W'(1), SAMPLE_W'(16'h00FF));
    send_beat(CH_W'(2), '1);
    send_beat(CH_W'(3), SAMPLE_W'(16'h5A5A));
    send_beat(CH_W'(4), SAMPLE_W'(16'hAAAA));
    send_beat(CH_W'(4), SAMPLE_W'(16'h5555));
    send_beat(CH_W'(5), '1);
    send_beat(CH_W'(5), '1);
    send_beat(CH_W'(5), '0);
    drain_results();

    // random phases, new windows between them
    for (int phase = 0; phase < PHASES; phase++) begin
      for (int i = 0; i < REG_SLOTS; i++) begin
        if (i >= NUM_CH)   window_plan[i] = WIN_CFG_W'($urandom_range(63));
        else if (phase == 0) window_plan[i] = WIN_CFG_W'(1);
        else if (phase == 1) window_plan[i] = WIN_CFG_W'(WIN_MAX);
        else               window_plan[i] = pick_window();
      end
      program_windows();
      no_idle <= (phase == 0);
      // receiver holds off while beats keep coming: the block backs up
      if (phase == 3) hold_request <= 1'b1;
      for (int n = 0; n < PHASE_BEATS; n++) begin
        // sender pause mid-phase until everything is back
        if (phase == 6 && n == PHASE_BEATS / 2) drain_results();
        send_beat(pick_channel(), pick_sample());
      end
      drain_results();
    end

    no_idle <= 1'b0;
    // room for any stray result beat to show up
    repeat (TAIL_CYCLES) @(posedge clk);
    if (tracker.mismatches == 0 && tracker.outstanding() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== multichannel_moving_average.f =====
src/mma_pkg.sv
src/mma_in_if.sv
src/mma_out_if.sv
src/mma_ram.sv
src/mma_div.sv
src/mma_ctrl.sv
src/mma_dpath.sv
src/multichannel_moving_average.sv
dv/multichannel_moving_average_tb.sv
